>>> rtl/core/wildcard_byte_pattern_scanner_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern scanner
// Shared assertion forms, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_MACROS_SVH

// same-cycle implication
`define WBPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbps assertion failed");

// next-cycle implication
`define WBPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wbps assertion failed");

`endif

>>> rtl/core/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Constants, register codes and shared types of the pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int OFFSET_BITS = 32;
  localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
  localparam int LANE_BITS   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int SIZE_W      = 6;
  localparam int CARE_W      = 32;
  localparam int WORDS       = 4;

  localparam int IN_TDATA_W  = 8;
  localparam int OFF_OUT_W   = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO     = 3'd0,
    REG_PAT_MID_LO = 3'd1,
    REG_PAT_MID_HI = 3'd2,
    REG_PAT_HI     = 3'd3,
    REG_CARE       = 3'd4,
    REG_SIZE       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                 found;
    logic [OFF_OUT_W-1:0] offset;
  } track_res_t;

endpackage

>>> rtl/core/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// One pattern position: compares the byte, holds its prefix-match bit and
// hands it to the next position.
// ----------------------------------------------------------------------------
module wbps_cell import wbps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       clr,
  input  logic [7:0] data_byte,
  input  logic [7:0] pat_byte,
  input  logic       care,
  input  logic       prev_bit,
  output logic       bit_nxt,
  output logic       bit_r
);

  logic hit;

  assign hit     = !care || (pat_byte == data_byte);
  assign bit_nxt = prev_bit && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else if (en) begin
      bit_r <= clr ? 1'b0 : bit_nxt;
    end
  end

endmodule

>>> rtl/core/wbps_tracker.sv
// ----------------------------------------------------------------------------
// wbps_tracker
// Byte offset counter and first-match capture for the current region.
// ----------------------------------------------------------------------------
module wbps_tracker import wbps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   clr,
  input  logic [MAX_PATTERN-1:0] bits_nxt,
  input  logic [LEN_BITS-1:0]    len,
  output track_res_t             res
);

  logic [OFFSET_BITS-1:0] byte_count_r, byte_count_nxt;
  logic                   match_seen_r, match_seen_nxt;
  logic [OFFSET_BITS-1:0] first_r, first_nxt;
  logic [LANE_BITS-1:0]   sel;
  logic                   complete;
  logic [OFFSET_BITS-1:0] start;

  assign sel = LANE_BITS'(len - LEN_BITS'(1));

  always_comb begin
    if (len == '0) begin
      complete = 1'b1;
      start    = byte_count_r;
    end else begin
      complete = bits_nxt[sel];
      start    = byte_count_r - OFFSET_BITS'(len) + OFFSET_BITS'(1);
    end
    match_seen_nxt = match_seen_r;
    first_nxt      = first_r;
    if (complete && !match_seen_r) begin
      match_seen_nxt = 1'b1;
      first_nxt      = start;
    end
    byte_count_nxt = byte_count_r + OFFSET_BITS'(1);
  end

  assign res.found  = match_seen_nxt;
  assign res.offset = match_seen_nxt ? OFF_OUT_W'(first_nxt) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      match_seen_r <= 1'b0;
      first_r      <= '0;
    end else if (en) begin
      if (clr) begin
        byte_count_r <= '0;
        match_seen_r <= 1'b0;
        first_r      <= '0;
      end else begin
        byte_count_r <= byte_count_nxt;
        match_seen_r <= match_seen_nxt;
        first_r      <= first_nxt;
      end
    end
  end

endmodule

>>> rtl/core/wildcard_byte_pattern_scanner_top.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_top
// Masked byte signature search over a streamed region, one byte per cycle.
//
//   channel | dir | contents
//   in_     | in  | tdata: data_byte; tlast: region_end
//   out_    | out | tdata: found, match_offset (one per region)
//   cfg_    | in  | we / index / data, pattern, care bits, size
//
// One byte per cycle through the row of compare cells; the prefix bits and
// the offset counter update in that same cycle.
// The region result is registered when its last byte is accepted.
// A waiting result stalls input only while out_tready is low.
// Synchronous active-low reset clears every register except out_res_r.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_top import wbps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // region_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] found, [32:1] match_offset
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [WORDS-1:0][CFG_DATA_W-1:0] pat_r;
  logic [CARE_W-1:0]                care_r;
  logic [SIZE_W-1:0]                size_r;
  logic [LEN_BITS-1:0]              len;
  logic                             en;
  logic [MAX_PATTERN-1:0]           bits_nxt;
  logic [MAX_PATTERN-1:0]           bits_r;
  track_res_t                       res;
  logic                             out_valid_r;
  track_res_t                       out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      care_r <= '0;
      size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LO:     pat_r[0] <= cfg_data;
        REG_PAT_MID_LO: pat_r[1] <= cfg_data;
        REG_PAT_MID_HI: pat_r[2] <= cfg_data;
        REG_PAT_HI:     pat_r[3] <= cfg_data;
        REG_CARE:       care_r   <= cfg_data[CARE_W-1:0];
        REG_SIZE:       size_r   <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign len = (size_r > SIZE_W'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN) : LEN_BITS'(size_r);

  assign in_tready = !out_valid_r || out_tready;
  assign en        = in_tvalid && in_tready;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    wbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .clr       (in_tlast),
      .data_byte (in_tdata[7:0]),
      .pat_byte  (pat_r[k/8][(k%8)*8 +: 8]),
      .care      (care_r[k]),
      .prev_bit  ((k == 0) ? 1'b1 : bits_r[(k == 0) ? 0 : k-1]),
      .bit_nxt   (bits_nxt[k]),
      .bit_r     (bits_r[k])
    );
  end

  wbps_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .clr      (in_tlast),
    .bits_nxt (bits_nxt),
    .len      (len),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_tlast) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OFF_OUT_W - 1){1'b0}}, out_res_r.offset, out_res_r.found};

endmodule

>>> rtl/core/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks of the pattern scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scanner_top_macros.svh"

module wbps_checker import wbps_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `WBPS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `WBPS_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tdata[0], out_tdata[OFF_OUT_W:1] == '0)
  `WBPS_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[OUT_TDATA_W-1:OFF_OUT_W+1] == '0)
  `WBPS_ASSERT_NXT(a_end_result, in_tvalid && in_tready && in_tlast, out_tvalid)
  `WBPS_ASSERT_IMP(a_ready_free, !out_tvalid || out_tready, in_tready)

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/tb_wildcard_byte_pattern_scanner_top.sv
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scanner_top
// Streams byte regions into the scanner and compares each region result
// (found flag and first match offset) with a local shift-and predictor, or
// with the row's expected values where a directed case gives them. A short
// table of directed cases comes first, then random configuration phases
// with planted, corrupted and noise regions under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_scanner_top;
  import wbps_pkg::*;

  localparam int TARGET_BYTES = 1450;
  localparam int SETTLE_CYCLES = 4;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  wildcard_byte_pattern_scanner_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scanner model state
  logic [CFG_DATA_W-1:0]  pat_word [WORDS];
  logic [CARE_W-1:0]      care_mask;
  logic [SIZE_W-1:0]      pat_size;
  logic [MAX_PATTERN-1:0] prefix_bits;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic                   match_seen;
  logic [OFFSET_BITS-1:0] first_start;

  track_res_t region_results_q[$];
  logic       pinned_valid = 1'b0;
  track_res_t pinned_res;
  int         mismatch_count = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;

  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_END, ROW_END_CHK} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  found;
    logic [OFF_OUT_W-1:0]  off;
  } row_t;

  row_t dir_rows [36] = '{
    '{ROW_END_CHK, REG_PAT_LO,     64'h00,                  1'b1, 32'd0},
    '{ROW_END_CHK, REG_PAT_LO,     64'hFF,                  1'b1, 32'd0},
    '{ROW_CFG,     REG_PAT_LO,     64'hFF00,                1'b0, 32'd0},
    '{ROW_CFG,     REG_CARE,       64'h3,                   1'b0, 32'd0},
    '{ROW_CFG,     REG_SIZE,       64'd2,                   1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'h00,                  1'b0, 32'd0},
    '{ROW_END_CHK, REG_PAT_LO,     64'hFF,                  1'b1, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'h00,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'h00,                  1'b0, 32'd0},
    '{ROW_END_CHK, REG_PAT_LO,     64'hFF,                  1'b1, 32'd2},
    '{ROW_END_CHK, REG_PAT_LO,     64'h00,                  1'b0, 32'd0},
    '{ROW_END_CHK, REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_CFG,     REG_CARE,       64'h2,                   1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'h12,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'h34,                  1'b0, 32'd0},
    '{ROW_END_CHK, REG_PAT_LO,     64'hFF,                  1'b1, 32'd0},
    '{ROW_CFG,     REG_PAT_LO,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_CFG,     REG_CARE,       64'hFFFF_FFFF,           1'b0, 32'd0},
    '{ROW_CFG,     REG_SIZE,       64'd3,                   1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'h00,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_END_CHK, REG_PAT_LO,     64'hFF,                  1'b1, 32'd3},
    '{ROW_CFG,     REG_PAT_MID_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_CFG,     REG_PAT_MID_HI, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_CFG,     REG_PAT_HI,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_CFG,     REG_SIZE,       64'd63,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_END_CHK, REG_PAT_LO,     64'hFF,                  1'b0, 32'd0},
    '{ROW_BYTE,    REG_PAT_LO,     64'h00,                  1'b0, 32'd0},
    '{ROW_END,     REG_PAT_LO,     64'hFF,                  1'b0, 32'd0}
  };

  function automatic logic [7:0] pat_byte(input int k);
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic int eff_size();
    return (pat_size > MAX_PATTERN) ? MAX_PATTERN : int'(pat_size);
  endfunction

  task automatic scan_byte(input logic [7:0] b, input logic last, output bit got,
                           output track_res_t res);
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] bits;
    logic [OFFSET_BITS-1:0] start;
    logic                   complete;
    int                     len;
    hit = '0;
    len = eff_size();
    for (int k = 0; k < MAX_PATTERN; k++)
      if (!care_mask[k] || pat_byte(k) == b) hit[k] = 1'b1;
    bits = ((prefix_bits << 1) | MAX_PATTERN'(1)) & hit;
    if (len == 0) begin
      complete = 1'b1;
      start = byte_pos;
    end else begin
      complete = bits[len-1];
      start = byte_pos - OFFSET_BITS'(len - 1);
    end
    if (complete && !match_seen) begin
      match_seen = 1'b1;
      first_start = start;
    end
    prefix_bits = bits;
    byte_pos = byte_pos + OFFSET_BITS'(1);
    got = last;
    res.found = match_seen;
    res.offset = match_seen ? first_start[OFF_OUT_W-1:0] : '0;
    if (last) begin
      prefix_bits = '0;
      byte_pos = '0;
      match_seen = 1'b0;
      first_start = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH t=%0t %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    bit         got;
    track_res_t res;
    track_res_t want;
    if (!rst_n) begin
      for (int i = 0; i < WORDS; i++) pat_word[i] = '0;
      care_mask = '0;
      pat_size = '0;
      prefix_bits = '0;
      byte_pos = '0;
      match_seen = 1'b0;
      first_start = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        scan_byte(in_tdata, in_tlast, got, res);
        if (got) begin
          if (pinned_valid) begin
            res = pinned_res;
            pinned_valid = 1'b0;
          end
          region_results_q.push_back(res);
        end
      end
      if (out_tvalid && out_tready) begin
        if (region_results_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_tdata[32:1], '0);
        end else begin
          want = region_results_q.pop_front();
          if (out_tdata[0] !== want.found)
            report_mismatch("found", {31'b0, out_tdata[0]}, {31'b0, want.found});
          if (out_tdata[32:1] !== want.offset)
            report_mismatch("match_offset", out_tdata[32:1], want.offset);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT_LO:     pat_word[0] = cfg_data;
          REG_PAT_MID_LO: pat_word[1] = cfg_data;
          REG_PAT_MID_HI: pat_word[2] = cfg_data;
          REG_PAT_HI:     pat_word[3] = cfg_data;
          REG_CARE:       care_mask = cfg_data[CARE_W-1:0];
          REG_SIZE:       pat_size = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // receiver stall pattern
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 80);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_tick % 4 == 0);
      default: out_tready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    int gap;
    cfg_we <= 1'b0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (region_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic pick_config();
    logic [CFG_DATA_W-1:0] w;
    int                    sel;
    for (int i = 0; i < WORDS; i++) begin
      sel = $urandom_range(0, 7);
      w = {$urandom, $urandom};
      if (sel == 0) w = '1;
      else if (sel == 1) w = '0;
      write_reg(cfg_reg_t'(i), w);
    end
    sel = $urandom_range(0, 9);
    w = {32'b0, $urandom};
    if (sel < 4) w = 64'hFFFF_FFFF;
    else if (sel == 4) w = '0;
    else if (sel < 7) w = {32'b0, $urandom | $urandom};
    write_reg(REG_CARE, w);
    sel = $urandom_range(0, 9);
    case (sel)
      0:       w = '0;
      1, 2, 3: w = CFG_DATA_W'($urandom_range(1, 6));
      4, 5:    w = CFG_DATA_W'($urandom_range(7, 16));
      6:       w = CFG_DATA_W'($urandom_range(17, 31));
      7:       w = CFG_DATA_W'(MAX_PATTERN);
      8:       w = CFG_DATA_W'($urandom_range(1, 4));
      default: w = CFG_DATA_W'($urandom_range(MAX_PATTERN + 1, 63));
    endcase
    write_reg(REG_SIZE, w);
  endtask

  function automatic logic [7:0] noise_byte(input int len);
    if (len > 0 && $urandom_range(0, 1) == 1) return pat_byte($urandom_range(0, len - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // planted, planted with a corrupted byte, or plain noise
  task automatic run_region();
    logic [7:0] region_q[$];
    int         len;
    int         kind;
    int         pre;
    int         pos;
    len = eff_size();
    kind = $urandom_range(0, 9);
    pre = $urandom_range(0, 8);
    repeat (pre) region_q.push_back(noise_byte(len));
    if (kind < 8) begin
      for (int k = 0; k < len; k++)
        region_q.push_back(care_mask[k] ? pat_byte(k) : 8'($urandom_range(0, 255)));
      if (kind >= 6 && len > 0) begin
        pos = pre + $urandom_range(0, len - 1);
        region_q[pos] = ~region_q[pos];
      end
    end
    repeat ($urandom_range(0, 8)) region_q.push_back(noise_byte(len));
    if (region_q.size() == 0) region_q.push_back(noise_byte(len));
    for (int i = 0; i < region_q.size(); i++)
      put_byte(region_q[i], i == region_q.size() - 1);
  endtask

  initial begin
    bit prev_cfg;
    prev_cfg = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!prev_cfg) drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        if (dir_rows[i].kind == ROW_END_CHK) begin
          pinned_res.found = dir_rows[i].found;
          pinned_res.offset = dir_rows[i].off;
          pinned_valid = 1'b1;
        end
        put_byte(dir_rows[i].val[7:0], dir_rows[i].kind != ROW_BYTE);
      end
      prev_cfg = (dir_rows[i].kind == ROW_CFG);
    end

    while (bytes_sent < TARGET_BYTES) begin
      drain_results();
      pick_config();
      repeat ($urandom_range(2, 6)) run_region();
    end

    in_tvalid <= 1'b0;
    while (region_results_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
